### design/stlf_pkg.sv
// ----------------------------------------------------------------------------
// stlf_pkg
// Shared constants, codes and the lowest-set-bit finder for the slot table.
// ----------------------------------------------------------------------------
package stlf_pkg;

    localparam int SLOTS      = 64;
    localparam int VALUE_BITS = 32;
    localparam int SLOT_BITS  = $clog2(SLOTS);
    localparam int CNT_BITS   = SLOT_BITS + 1;

    // operation codes
    localparam logic [1:0] MODE_ADD    = 2'd0;
    localparam logic [1:0] MODE_REMOVE = 2'd1;
    localparam logic [1:0] MODE_REWIND = 2'd2;
    localparam logic [1:0] MODE_NEXT   = 2'd3;

    // result status codes
    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_END    = 2'd2;

    typedef struct packed {
        logic load;   // latch the incoming operation
        logic exec;   // run the operation against the table
    } stlf_cmd_t;

    // Returns {any, index of lowest set bit}. The lowest set bit is isolated
    // with one add, then encoded by an OR over independent terms.
    function automatic logic [SLOT_BITS:0] find_lowest(input logic [SLOTS-1:0] v);
        logic [SLOTS-1:0]     iso;
        logic [SLOT_BITS-1:0] idx;
        begin
            iso = v & (~v + SLOTS'(1));
            idx = '0;
            for (int i = 0; i < SLOTS; i++)
            begin
                if (iso[i])
                begin
                    idx = idx | SLOT_BITS'(i);
                end
            end
            return {|v, idx};
        end
    endfunction

endpackage

### design/stlf_ctrl.sv
// ----------------------------------------------------------------------------
// stlf_ctrl
// Operation sequencer: idle, execute, report.
// ----------------------------------------------------------------------------
module stlf_ctrl
    import stlf_pkg::*;
(
    input  logic      clk,
    input  logic      rst_n,
    input  logic      start,
    output logic      busy,
    output logic      done,
    output stlf_cmd_t cmd
);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_EXEC = 2'd1;
    localparam logic [1:0] S_DONE = 2'd2;

    logic [1:0] state_reg;
    logic [1:0] state_next;
    logic       accept;

    assign busy   = (state_reg == S_EXEC);
    assign done   = (state_reg == S_DONE);
    assign accept = start && !busy;

    assign cmd.load = accept;
    assign cmd.exec = busy;

    // a new transfer may be taken in the same cycle the result is shown
    always_comb
    begin
        case (state_reg)
            S_IDLE:  state_next = accept ? S_EXEC : S_IDLE;
            S_EXEC:  state_next = S_DONE;
            S_DONE:  state_next = accept ? S_EXEC : S_IDLE;
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

### design/stlf_dp.sv
// ----------------------------------------------------------------------------
// stlf_dp
// Slot table datapath: valid marks, bounds, walk cursor, entry memory.
// ----------------------------------------------------------------------------
module stlf_dp
    import stlf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  stlf_cmd_t             cmd,
    input  logic [1:0]            mode,
    input  logic [SLOT_BITS-1:0]  slot_index,
    input  logic [VALUE_BITS-1:0] entry_value,
    output logic [1:0]            status,
    output logic [SLOT_BITS-1:0]  found_slot,
    output logic [VALUE_BITS-1:0] found_value,
    output logic [CNT_BITS-1:0]   occupied_count
);

    localparam logic [SLOTS-1:0] ONES = {SLOTS{1'b1}};

    // latched operation
    logic [1:0]            op_mode_reg;
    logic [SLOT_BITS-1:0]  op_index_reg;
    logic [VALUE_BITS-1:0] op_value_reg;

    // table state
    logic [SLOTS-1:0]    valid_reg,  valid_next;
    logic [CNT_BITS-1:0] lf_reg,     lf_next;
    logic [CNT_BITS-1:0] hw_reg,     hw_next;
    logic [CNT_BITS-1:0] cursor_reg, cursor_next;
    logic [CNT_BITS-1:0] count_reg,  count_next;

    // result
    logic [1:0]           status_reg, status_next;
    logic [SLOT_BITS-1:0] slot_reg,   slot_next;
    logic                 hit_reg,    hit_next;

    // entry memory
    logic [VALUE_BITS-1:0] mem [SLOTS];
    logic [VALUE_BITS-1:0] rd_data_reg;
    logic                  mem_we;
    logic                  mem_re;

    logic [SLOT_BITS-1:0] placed;
    logic [CNT_BITS-1:0]  placed_inc;
    logic [CNT_BITS-1:0]  index_ext;
    logic [SLOTS-1:0]     below_hw;
    logic [SLOTS-1:0]     add_cand;
    logic [SLOTS-1:0]     next_cand;
    logic [SLOTS-1:0]     cand;
    logic [SLOT_BITS:0]   fnd;
    logic                 fnd_any;
    logic [SLOT_BITS-1:0] fnd_idx;
    logic                 full;

    assign placed     = lf_reg[SLOT_BITS-1:0];
    assign placed_inc = lf_reg + CNT_BITS'(1);
    assign index_ext  = {1'b0, op_index_reg};
    assign below_hw   = ~(ONES << hw_reg);
    assign add_cand   = ~valid_reg & (ONES << placed_inc) & below_hw;
    assign next_cand  = valid_reg & (ONES << cursor_reg) & below_hw;
    assign cand       = (op_mode_reg == MODE_ADD) ? add_cand : next_cand;
    assign fnd        = find_lowest(cand);
    assign fnd_any    = fnd[SLOT_BITS];
    assign fnd_idx    = fnd[SLOT_BITS-1:0];
    assign full       = (count_reg == CNT_BITS'(SLOTS)) || lf_reg[SLOT_BITS];

    always_comb
    begin
        valid_next  = valid_reg;
        lf_next     = lf_reg;
        hw_next     = hw_reg;
        cursor_next = cursor_reg;
        count_next  = count_reg;
        status_next = ST_OK;
        slot_next   = '0;
        hit_next    = 1'b0;
        mem_we      = 1'b0;
        mem_re      = 1'b0;

        case (op_mode_reg)
            MODE_ADD:
            begin
                if (full)
                begin
                    status_next = ST_REJECT;
                end
                else
                begin
                    mem_we             = 1'b1;
                    valid_next[placed] = 1'b1;
                    count_next         = count_reg + CNT_BITS'(!valid_reg[placed]);
                    slot_next          = placed;
                    if (fnd_any)
                    begin
                        lf_next = {1'b0, fnd_idx};
                    end
                    else if (lf_reg >= hw_reg)
                    begin
                        hw_next = placed_inc;
                        lf_next = placed_inc;
                    end
                    else
                    begin
                        lf_next = hw_reg;
                    end
                end
            end
            MODE_REMOVE:
            begin
                if (index_ext >= hw_reg)
                begin
                    status_next = ST_REJECT;
                end
                else
                begin
                    valid_next[op_index_reg] = 1'b0;
                    count_next = count_reg - CNT_BITS'(valid_reg[op_index_reg]);
                    if (index_ext < lf_reg)
                    begin
                        lf_next = index_ext;
                    end
                    if (index_ext + CNT_BITS'(1) == hw_reg)
                    begin
                        hw_next = index_ext;
                    end
                end
            end
            MODE_REWIND:
            begin
                cursor_next = '0;
            end
            MODE_NEXT:
            begin
                if (fnd_any)
                begin
                    mem_re      = 1'b1;
                    hit_next    = 1'b1;
                    slot_next   = fnd_idx;
                    cursor_next = {1'b0, fnd_idx} + CNT_BITS'(1);
                end
                else
                begin
                    status_next = ST_END;
                    if (cursor_reg < hw_reg)
                    begin
                        cursor_next = hw_reg;
                    end
                end
            end
            default:
            begin
                status_next = ST_REJECT;
            end
        endcase
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            op_mode_reg  <= mode;
            op_index_reg <= slot_index;
            op_value_reg <= entry_value;
        end
        if (cmd.exec)
        begin
            status_reg <= status_next;
            slot_reg   <= slot_next;
            hit_reg    <= hit_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.exec && mem_we)
        begin
            mem[placed] <= op_value_reg;
        end
        if (cmd.exec && mem_re)
        begin
            rd_data_reg <= mem[fnd_idx];
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg  <= '0;
            lf_reg     <= '0;
            hw_reg     <= '0;
            cursor_reg <= '0;
            count_reg  <= '0;
        end
        else if (cmd.exec)
        begin
            valid_reg  <= valid_next;
            lf_reg     <= lf_next;
            hw_reg     <= hw_next;
            cursor_reg <= cursor_next;
            count_reg  <= count_next;
        end
    end

    assign status         = status_reg;
    assign found_slot     = slot_reg;
    assign found_value    = hit_reg ? rd_data_reg : '0;
    assign occupied_count = count_reg;

endmodule

### design/slot_table_lowest_free_alloc.sv
// ----------------------------------------------------------------------------
// slot_table_lowest_free_alloc
// Slot table with lowest-free allocation, remove and ordered walk.
// The result strobe (done) follows the start transfer through the execute
// state, in which the search, update and registered entry memory read occur;
// no new start is taken while busy.
// A new start is taken in the cycle the previous result is shown.
// Reset clears all valid marks, the bounds, the cursor and the count at once.
// ----------------------------------------------------------------------------
module slot_table_lowest_free_alloc
    import stlf_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    output logic                  busy,
    input  logic [1:0]            mode,
    input  logic [SLOT_BITS-1:0]  slot_index,
    input  logic [VALUE_BITS-1:0] entry_value,
    output logic                  done,
    output logic [1:0]            status,
    output logic [SLOT_BITS-1:0]  found_slot,
    output logic [VALUE_BITS-1:0] found_value,
    output logic [CNT_BITS-1:0]   occupied_count
);

    stlf_cmd_t cmd;

    stlf_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .start (start),
        .busy  (busy),
        .done  (done),
        .cmd   (cmd)
    );

    stlf_dp u_dp (
        .clk            (clk),
        .rst_n          (rst_n),
        .cmd            (cmd),
        .mode           (mode),
        .slot_index     (slot_index),
        .entry_value    (entry_value),
        .status         (status),
        .found_slot     (found_slot),
        .found_value    (found_value),
        .occupied_count (occupied_count)
    );

endmodule

### design/stlf_chk.sv
// ----------------------------------------------------------------------------
// stlf_chk
// Port-level checks on the slot table's sequencing and results.
// ----------------------------------------------------------------------------
module stlf_chk
    import stlf_pkg::*;
(
    input logic                  clk,
    input logic                  rst_n,
    input logic                  start,
    input logic                  busy,
    input logic                  done,
    input logic [1:0]            status,
    input logic [SLOT_BITS-1:0]  found_slot,
    input logic [VALUE_BITS-1:0] found_value,
    input logic [CNT_BITS-1:0]   occupied_count
);

    // an accepted transfer is executed in the next cycle
    a_accept_exec: assert property (@(posedge clk) disable iff (!rst_n)
        (start && !busy) |=> busy)
        else $error("accepted transfer not executed");

    // execution always ends in exactly one result strobe
    a_exec_done: assert property (@(posedge clk) disable iff (!rst_n)
        busy |=> (done && !busy))
        else $error("execute cycle not followed by result");

    // result never overlaps execution
    a_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> !busy)
        else $error("result shown while busy");

    // rejected or exhausted operations report no slot and no word
    a_fail_clean: assert property (@(posedge clk) disable iff (!rst_n)
        (done && status != ST_OK) |-> (found_slot == '0 && found_value == '0))
        else $error("failing result carries data");

    // count never exceeds the table size
    a_count: assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (occupied_count <= CNT_BITS'(SLOTS)))
        else $error("occupied count out of range");

endmodule

bind slot_table_lowest_free_alloc stlf_chk u_chk (.*);

### sim/slot_table_lowest_free_alloc_test.sv
// ----------------------------------------------------------------------------
// slot_table_lowest_free_alloc_test
// Self-checking bench for the slot table: directed corner operations, then
// random add/remove/walk traffic steered by the live table occupancy, run
// under several start-idling phases and scored against a behavioral table.
// ----------------------------------------------------------------------------
module slot_table_lowest_free_alloc_test;

    import stlf_pkg::*;

    typedef struct packed {
        logic [1:0]            mode;
        logic [SLOT_BITS-1:0]  slot_index;
        logic [VALUE_BITS-1:0] entry_value;
    } table_op_t;

    typedef struct packed {
        logic [1:0]            status;
        logic [SLOT_BITS-1:0]  found_slot;
        logic [VALUE_BITS-1:0] found_value;
        logic [CNT_BITS-1:0]   occupied_count;
    } table_result_t;

    logic                  clk = 1'b0;
    logic                  rst_n = 1'b0;
    logic                  start = 1'b0;
    logic [1:0]            mode = MODE_REWIND;
    logic [SLOT_BITS-1:0]  slot_index = '0;
    logic [VALUE_BITS-1:0] entry_value = '0;
    logic                  busy;
    logic                  done;
    logic [1:0]            status;
    logic [SLOT_BITS-1:0]  found_slot;
    logic [VALUE_BITS-1:0] found_value;
    logic [CNT_BITS-1:0]   occupied_count;

    slot_table_lowest_free_alloc dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .start          (start),
        .busy           (busy),
        .mode           (mode),
        .slot_index     (slot_index),
        .entry_value    (entry_value),
        .done           (done),
        .status         (status),
        .found_slot     (found_slot),
        .found_value    (found_value),
        .occupied_count (occupied_count)
    );

    // behavioral copy of the table
    logic [VALUE_BITS-1:0] shadow_word [SLOTS];
    bit                    shadow_used [SLOTS];
    int                    free_ptr = 0;
    int                    bound = 0;
    int                    cursor = 0;

    table_op_t     op_backlog [$];
    table_result_t predicted_results [$];

    int idle_pct = 0;
    int errors = 0;
    int ops_done = 0;
    int full_rejects = 0;
    int bound_rejects = 0;
    int hole_removes = 0;
    int walk_ends = 0;
    int peak_used = 0;

    // generator steering
    int walk_left = 0;
    int trend = 0;
    int trend_left = 120;

    function automatic int used_count();
        int n;
        n = 0;
        for (int i = 0; i < SLOTS; i++)
        begin
            if (shadow_used[i])
            begin
                n++;
            end
        end
        return n;
    endfunction

    // apply one operation to the behavioral table and return its result
    function automatic table_result_t table_apply(table_op_t op);
        table_result_t res;
        int            placed;
        bit            hit;
        begin
            res = '0;
            res.status = ST_OK;
            case (op.mode)
                MODE_ADD:
                begin
                    if (used_count() >= SLOTS || free_ptr >= SLOTS)
                    begin
                        res.status = ST_REJECT;
                        full_rejects++;
                    end
                    else
                    begin
                        placed = free_ptr;
                        shadow_word[placed] = op.entry_value;
                        shadow_used[placed] = 1'b1;
                        res.found_slot = placed[SLOT_BITS-1:0];
                        hit = 1'b0;
                        for (int i = placed + 1; i < bound && i < SLOTS && !hit; i++)
                        begin
                            if (!shadow_used[i])
                            begin
                                free_ptr = i;
                                hit = 1'b1;
                            end
                        end
                        if (!hit)
                        begin
                            if (placed >= bound)
                            begin
                                bound = placed + 1;
                            end
                            free_ptr = bound;
                        end
                    end
                end
                MODE_REMOVE:
                begin
                    if (int'(op.slot_index) >= bound)
                    begin
                        res.status = ST_REJECT;
                        bound_rejects++;
                    end
                    else
                    begin
                        if (!shadow_used[op.slot_index])
                        begin
                            hole_removes++;
                        end
                        shadow_used[op.slot_index] = 1'b0;
                        if (int'(op.slot_index) < free_ptr)
                        begin
                            free_ptr = int'(op.slot_index);
                        end
                        if (int'(op.slot_index) + 1 == bound)
                        begin
                            bound = int'(op.slot_index);
                        end
                    end
                end
                MODE_REWIND:
                begin
                    cursor = 0;
                end
                default:
                begin
                    hit = 1'b0;
                    for (int i = cursor; i < bound && i < SLOTS && !hit; i++)
                    begin
                        if (shadow_used[i])
                        begin
                            res.found_slot = i[SLOT_BITS-1:0];
                            res.found_value = shadow_word[i];
                            cursor = i + 1;
                            hit = 1'b1;
                        end
                    end
                    if (!hit)
                    begin
                        res.status = ST_END;
                        walk_ends++;
                        if (cursor < bound)
                        begin
                            cursor = bound;
                        end
                    end
                end
            endcase
            res.occupied_count = CNT_BITS'(used_count());
            if (used_count() > peak_used)
            begin
                peak_used = used_count();
            end
            return res;
        end
    endfunction

    function automatic logic [VALUE_BITS-1:0] pick_word();
        case ($urandom_range(9))
            0:       return '0;
            1:       return '1;
            default: return $urandom;
        endcase
    endfunction

    // random operation in a grow, shrink or mix trend; walk length and remove index follow the table
    function automatic table_op_t pick_op();
        table_op_t op;
        int        r;
        int        add_cut;
        begin
            op.mode = MODE_NEXT;
            op.slot_index = SLOT_BITS'($urandom_range(SLOTS - 1));
            op.entry_value = pick_word();
            if (walk_left > 0)
            begin
                walk_left--;
            end
            else
            begin
                if (trend_left == 0)
                begin
                    trend = $urandom_range(2);
                    trend_left = $urandom_range(30, 90);
                end
                trend_left--;
                case (trend)
                    0:       add_cut = 11 + 80 * 89 / 100;
                    1:       add_cut = 11 + 25 * 89 / 100;
                    default: add_cut = 11 + 50 * 89 / 100;
                endcase
                r = $urandom_range(99);
                if (r < 8)
                begin
                    op.mode = MODE_REWIND;
                    if ($urandom_range(3) == 0)
                    begin
                        walk_left = $urandom_range(used_count() + 2);
                    end
                    else
                    begin
                        walk_left = $urandom_range(8);
                    end
                end
                else if (r >= 11 && r < add_cut)
                begin
                    op.mode = MODE_ADD;
                end
                else if (r >= add_cut)
                begin
                    op.mode = MODE_REMOVE;
                    if (bound > 0 && $urandom_range(9) < 8)
                    begin
                        op.slot_index = SLOT_BITS'($urandom_range(bound - 1));
                    end
                end
            end
            return op;
        end
    endfunction

    task automatic check_field(input string name, input logic [31:0] want,
                               input logic [31:0] got);
        if (got !== want)
        begin
            $display("%0t: %s mismatch, expected %0h, actual %0h", $time, name, want, got);
            errors++;
        end
    endtask

    initial
    begin
        forever #5 clk = ~clk;
    end

    // driver: scores each transfer, then presents the next backlog item
    always @(posedge clk)
    begin
        table_op_t cur;
        table_op_t nxt;
        if (rst_n)
        begin
            if (start && !busy)
            begin
                cur.mode = mode;
                cur.slot_index = slot_index;
                cur.entry_value = entry_value;
                predicted_results.push_back(table_apply(cur));
                ops_done++;
            end
            if (!(start && busy))
            begin
                if (op_backlog.size() > 0 && $urandom_range(99) >= idle_pct)
                begin
                    nxt = op_backlog.pop_front();
                    start <= 1'b1;
                    mode <= nxt.mode;
                    slot_index <= nxt.slot_index;
                    entry_value <= nxt.entry_value;
                end
                else
                begin
                    start <= 1'b0;
                end
            end
        end
    end

    // monitor: each strobe is compared with the oldest prediction
    always @(posedge clk)
    begin
        table_result_t want;
        if (rst_n && done)
        begin
            if (predicted_results.size() == 0)
            begin
                $display("%0t: unexpected result, expected none, actual status %0d slot %0d",
                         $time, status, found_slot);
                errors++;
            end
            else
            begin
                want = predicted_results.pop_front();
                check_field("status", 32'(want.status), 32'(status));
                check_field("found_slot", 32'(want.found_slot), 32'(found_slot));
                check_field("found_value", 32'(want.found_value), 32'(found_value));
                check_field("occupied_count", 32'(want.occupied_count),
                            32'(occupied_count));
            end
        end
    end

    initial
    begin
        #2000000;
        $display("[FAIL] regression broken");
        $finish;
    end

    initial
    begin
        table_op_t op;
        int        phase_pct [4];
        phase_pct[0] = 0;
        phase_pct[1] = 52;
        phase_pct[2] = 0;
        phase_pct[3] = 16;
        for (int i = 0; i < SLOTS; i++)
        begin
            shadow_word[i] = '0;
            shadow_used[i] = 1'b0;
        end
        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: empty-table walk, reject past the bound, extreme words,
        // hole removal below the bound, bound pulled in, walk past the end
        op_backlog.push_back('{MODE_NEXT, 6'd0, 32'h0});
        op_backlog.push_back('{MODE_REMOVE, 6'd0, 32'h0});
        op_backlog.push_back('{MODE_ADD, 6'd63, 32'h0000_0000});
        op_backlog.push_back('{MODE_ADD, 6'd0, 32'hFFFF_FFFF});
        op_backlog.push_back('{MODE_ADD, 6'd21, 32'hA5A5_A5A5});
        op_backlog.push_back('{MODE_ADD, 6'd42, 32'h5A5A_5A5A});
        op_backlog.push_back('{MODE_REWIND, 6'd63, 32'hFFFF_FFFF});
        repeat (5) op_backlog.push_back('{MODE_NEXT, 6'd0, 32'h0});
        op_backlog.push_back('{MODE_REMOVE, 6'd63, 32'h0});
        op_backlog.push_back('{MODE_REMOVE, 6'd4, 32'h0});
        op_backlog.push_back('{MODE_REMOVE, 6'd1, 32'h0});
        op_backlog.push_back('{MODE_REMOVE, 6'd1, 32'h0});
        op_backlog.push_back('{MODE_ADD, 6'd0, 32'h1234_5678});
        op_backlog.push_back('{MODE_REMOVE, 6'd3, 32'h0});
        op_backlog.push_back('{MODE_REWIND, 6'd0, 32'h0});
        op_backlog.push_back('{MODE_NEXT, 6'd0, 32'h0});
        op_backlog.push_back('{MODE_NEXT, 6'd0, 32'h0});
        op_backlog.push_back('{MODE_REMOVE, 6'd0, 32'h0});
        op_backlog.push_back('{MODE_NEXT, 6'd0, 32'h0});

        for (int p = 0; p < 4; p++)
        begin
            idle_pct = phase_pct[p];
            for (int n = 0; n < 300; n++)
            begin
                // keep one item ahead so steering sees a near-current table
                while (op_backlog.size() > 0)
                begin
                    @(negedge clk);
                end
                op = pick_op();
                op_backlog.push_back(op);
            end
        end

        while (op_backlog.size() > 0 || start || predicted_results.size() > 0)
        begin
            @(negedge clk);
        end
        repeat (6) @(negedge clk);

        $display("Ran %0d operations, peak occupancy %0d of %0d slots.",
                 ops_done, peak_used, SLOTS);
        $display("Full-table adds %0d, out-of-bound removes %0d, hole removes %0d, walk ends %0d.",
                 full_rejects, bound_rejects, hole_removes, walk_ends);
        if (errors == 0)
        begin
            $display("[ OK ] regression clean");
        end
        else
        begin
            $display("[FAIL] regression broken");
        end
        $finish;
    end

endmodule
